[hw/rtl/inplace_fade_blur_stream_assert.svh]
// Assertion macros shared by the fade blur RTL.
`ifndef INPLACE_FADE_BLUR_STREAM_ASSERT_SVH
`define INPLACE_FADE_BLUR_STREAM_ASSERT_SVH

// same-cycle implication
`define IFB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IFB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ifb_pkg.sv]
// Types and constants shared by the fade blur modules.
package ifb_pkg;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int PIX_W     = 24;

  localparam logic [PIX_W-1:0] CHAN_MASK = 24'hFCFCFC;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd570;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd105;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic FN_PIXEL = 1'b0;
  localparam logic FN_FLUSH = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_SUM   = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_RUN   = 5'b10000
  } ifb_state_t;

  typedef struct packed {
    logic vld;
    logic clr;
    logic out_en;
    logic up_en;
    logic left_en;
    logic last;
  } ifb_issue_t;

endpackage

[hw/rtl/inplace_fade_blur_stream.sv]
// Top level of the in-place four-neighbor fade blur stream.
// One item per clock, sustained, while the output is not stalled, once the block
// is set up. Pixel k passes the stage-two and output registers after the item W
// positions later is taken, so W flush items end each frame; frame_last marks
// pixel W*H-1 and the next frame starts right after. Both line buffers are
// synchronous memories; the only feedback is the left-neighbor masked add in
// stage two. After reset the input stalls while both line buffers clear, then
// while the frame size is multiplied out and the ring position is found by a
// bit-serial divider over CW bits (CW = clog2(MAX_WIDTH*MAX_HEIGHT+MAX_WIDTH),
// 21 at the defaults); every configuration write stalls the input in its own
// cycle and then through the same multiply, sum and divide setup.
module inplace_fade_blur_stream import ifb_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_func,
  input  logic [PIX_W-1:0]     in_pixel_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PIX_W-1:0]     out_pixel_out,
  output logic                 out_frame_last
);

  localparam int AW = $clog2(MAX_WIDTH);

  ifb_issue_t       iss;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [PIX_W-1:0] iss_pix;
  logic             dp_busy;

  ifb_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_func     (in_func),
    .in_pixel_in (in_pixel_in),
    .in_stall    (in_stall),
    .dp_busy     (dp_busy),
    .iss         (iss),
    .wr_addr     (wr_addr),
    .rd_addr     (rd_addr),
    .iss_pix     (iss_pix)
  );

  ifb_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .iss            (iss),
    .wr_addr        (wr_addr),
    .rd_addr        (rd_addr),
    .iss_pix        (iss_pix),
    .dp_busy        (dp_busy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_out  (out_pixel_out),
    .out_frame_last (out_frame_last)
  );

endmodule

[hw/rtl/ifb_ctrl.sv]
// Frame sequencer: config registers, ring position, clear pass and setup divider.
`include "inplace_fade_blur_stream_assert.svh"

module ifb_ctrl import ifb_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]             cfg_data,
  input  logic                         in_valid,
  input  logic                         in_func,
  input  logic [PIX_W-1:0]             in_pixel_in,
  output logic                         in_stall,
  input  logic                         dp_busy,
  output ifb_issue_t                   iss,
  output logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  output logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  output logic [PIX_W-1:0]             iss_pix
);

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int CW  = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH);
  localparam int DCW = $clog2(CW + 1);

  ifb_state_t      st_r, st_nxt;
  logic [CFG_W-1:0] fw_r, fw_nxt, fh_r, fh_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [AW-1:0]   p_r, p_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic [CW-1:0]   n_r, n_nxt, last_th_r, last_th_nxt, w2_r, w2_nxt;
  logic [CW-1:0]   div_q_r, div_q_nxt;
  logic [WW-1:0]   div_rem_r, div_rem_nxt;
  logic [DCW-1:0]  div_cnt_r, div_cnt_nxt;

  logic [WW-1:0] w_eff, p_inc;
  logic [HW-1:0] h_eff;
  logic [CW-1:0] w_cw;
  logic [AW-1:0] p_wrap;
  logic [WW:0]   div_sh, div_sub;
  logic          acc, cur_en, last;

  always_comb begin
    if (fw_r < CFG_W'(2)) begin
      w_eff = WW'(2);
    end else if (32'(fw_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_r);
    end
    if (fh_r < CFG_W'(1)) begin
      h_eff = HW'(1);
    end else if (32'(fh_r) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(fh_r);
    end
  end

  assign w_cw   = CW'(w_eff);
  assign p_inc  = WW'(p_r) + WW'(1);
  assign p_wrap = (p_inc == w_eff) ? '0 : p_inc[AW-1:0];

  assign in_stall = (st_r != ST_RUN) || cfg_we || dp_busy;
  assign acc      = in_valid && !in_stall;
  assign cur_en   = (cnt_r < n_r) && (in_func == FN_PIXEL);
  assign last     = (cnt_r >= w_cw) && (cnt_r >= last_th_r);

  always_comb begin
    iss.vld     = acc;
    iss.clr     = (st_r == ST_CLEAR);
    iss.out_en  = cnt_r >= w_cw;
    iss.up_en   = cnt_r >= w2_r;
    iss.left_en = cnt_r != w_cw;
    iss.last    = last;
  end

  assign wr_addr = (st_r == ST_CLEAR) ? clr_r : p_r;
  assign rd_addr = p_wrap;
  assign iss_pix = (acc && cur_en) ? in_pixel_in : '0;

  assign div_sh  = {div_rem_r, div_q_r[CW-1]};
  assign div_sub = (div_sh >= {1'b0, w_eff}) ? (div_sh - {1'b0, w_eff}) : div_sh;

  always_comb begin
    st_nxt      = st_r;
    fw_nxt      = fw_r;
    fh_nxt      = fh_r;
    cnt_nxt     = cnt_r;
    p_nxt       = p_r;
    clr_nxt     = clr_r;
    n_nxt       = n_r;
    last_th_nxt = last_th_r;
    w2_nxt      = w2_r;
    div_q_nxt   = div_q_r;
    div_rem_nxt = div_rem_r;
    div_cnt_nxt = div_cnt_r;
    case (st_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(MAX_WIDTH - 1)) begin
          st_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        n_nxt  = w_cw * CW'(h_eff);
        st_nxt = ST_SUM;
      end
      ST_SUM: begin
        last_th_nxt = n_r + w_cw - CW'(1);
        w2_nxt      = w_cw << 1;
        div_q_nxt   = cnt_r;
        div_rem_nxt = '0;
        div_cnt_nxt = '0;
        st_nxt      = ST_DIV;
      end
      ST_DIV: begin
        div_rem_nxt = div_sub[WW-1:0];
        div_q_nxt   = div_q_r << 1;
        div_cnt_nxt = div_cnt_r + DCW'(1);
        if (div_cnt_r == DCW'(CW - 1)) begin
          p_nxt  = div_sub[AW-1:0];
          st_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (acc) begin
          cnt_nxt = last ? '0 : cnt_r + CW'(1);
          p_nxt   = last ? '0 : p_wrap;
        end
      end
      default: begin
        st_nxt = ST_CLEAR;
      end
    endcase
    if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  fw_nxt = cfg_data;
        REG_FRAME_HEIGHT: fh_nxt = cfg_data;
        default: ;
      endcase
      if (st_r != ST_CLEAR) begin
        st_nxt = ST_MUL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_CLEAR;
      fw_r  <= WIDTH_RESET;
      fh_r  <= HEIGHT_RESET;
      cnt_r <= '0;
      p_r   <= '0;
      clr_r <= '0;
    end else begin
      st_r  <= st_nxt;
      fw_r  <= fw_nxt;
      fh_r  <= fh_nxt;
      cnt_r <= cnt_nxt;
      p_r   <= p_nxt;
      clr_r <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    last_th_r <= last_th_nxt;
    w2_r      <= w2_nxt;
    div_q_r   <= div_q_nxt;
    div_rem_r <= div_rem_nxt;
    div_cnt_r <= div_cnt_nxt;
  end

  `IFB_ASSERT_IMPL(a_ptr_in_range, st_r == ST_RUN, WW'(p_r) < w_eff, "ring position out of range")
  `IFB_ASSERT_NEXT(a_frame_wrap, acc && last, cnt_r == '0 && p_r == '0, "frame did not restart")
  `IFB_ASSERT_NEXT(a_cfg_setup, cfg_we && st_r != ST_CLEAR, st_r == ST_MUL, "no setup after write")

endmodule

[hw/rtl/ifb_datapath.sv]
// Line memories, blur adder, left-neighbor feedback and output register.
`include "inplace_fade_blur_stream_assert.svh"

module ifb_datapath import ifb_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ifb_issue_t                   iss,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  logic [PIX_W-1:0]             iss_pix,
  output logic                         dp_busy,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [PIX_W-1:0]             out_pixel_out,
  output logic                         out_frame_last
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic [PIX_W-1:0] la_mem [MAX_WIDTH];
  logic [PIX_W-1:0] bl_mem [MAX_WIDTH];
  logic [PIX_W-1:0] la_q_r, bl_q_r;

  logic             s2_v_r, s2_v_nxt;
  logic             s2_up_r, s2_left_r, s2_last_r;
  logic [PIX_W-1:0] s2_pix_r;
  logic [AW-1:0]    s2_addr_r;
  logic [PIX_W-1:0] prev_r, prev_nxt;
  logic             out_v_r, out_v_nxt;
  logic [PIX_W-1:0] out_pix_r;
  logic             out_last_r;

  logic             s2_go, s2_load, bl_we;
  logic [AW-1:0]    bl_waddr;
  logic [PIX_W-1:0] up_px, left_px, val, bl_wdata;
  logic [PIX_W+1:0] sum;

  assign s2_go   = s2_v_r && (!out_v_r || !out_stall);
  assign s2_load = iss.vld && iss.out_en;
  assign dp_busy = s2_v_r && out_v_r && out_stall;

  assign up_px   = s2_up_r ? bl_q_r : '0;
  assign left_px = s2_left_r ? prev_r : '0;
  assign sum     = {2'b00, up_px & CHAN_MASK} + {2'b00, left_px & CHAN_MASK}
                 + {2'b00, la_q_r & CHAN_MASK} + {2'b00, s2_pix_r & CHAN_MASK};
  assign val     = sum[PIX_W+1:2];

  assign bl_we    = iss.clr || s2_go;
  assign bl_waddr = iss.clr ? wr_addr : s2_addr_r;
  assign bl_wdata = iss.clr ? '0 : val;

  always_ff @(posedge clk) begin
    if (iss.clr || iss.vld) begin
      la_mem[wr_addr] <= iss_pix;
    end
    if (iss.vld) begin
      la_q_r <= la_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (bl_we) begin
      bl_mem[bl_waddr] <= bl_wdata;
    end
    if (iss.vld) begin
      bl_q_r <= bl_mem[wr_addr];
    end
  end

  always_comb begin
    s2_v_nxt  = s2_v_r;
    prev_nxt  = prev_r;
    out_v_nxt = out_v_r;
    if (s2_go) begin
      s2_v_nxt  = 1'b0;
      prev_nxt  = s2_last_r ? '0 : val;
      out_v_nxt = 1'b1;
    end else if (out_v_r && !out_stall) begin
      out_v_nxt = 1'b0;
    end
    if (s2_load) begin
      s2_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      prev_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      s2_v_r  <= s2_v_nxt;
      prev_r  <= prev_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_up_r   <= iss.up_en;
      s2_left_r <= iss.left_en;
      s2_last_r <= iss.last;
      s2_pix_r  <= iss_pix;
      s2_addr_r <= wr_addr;
    end
    if (s2_go) begin
      out_pix_r  <= val;
      out_last_r <= s2_last_r;
    end
  end

  assign out_valid      = out_v_r;
  assign out_pixel_out  = out_pix_r;
  assign out_frame_last = out_last_r;

  `IFB_ASSERT_IMPL(a_no_issue_busy, dp_busy, !iss.vld, "item issued into a full pipe")
  `IFB_ASSERT_NEXT(a_s2_loaded, s2_load, s2_v_r, "issued item lost before stage two")
  `IFB_ASSERT_NEXT(a_out_loaded, s2_go, out_v_r, "blurred pixel lost before output")

endmodule

[test/tb_inplace_fade_blur_stream.sv]
// Testbench for inplace_fade_blur_stream: directed and random frames checked against a predictor.
`timescale 1ns / 100ps

module tb_inplace_fade_blur_stream;
  import ifb_pkg::*;

  localparam int MAX_W = 1024;
  localparam int MAX_H = 1024;
  localparam int RANDOM_ITEMS = 600;
  localparam int IDLE_LIMIT = 6000;
  localparam int SETTLE_CYCLES = 8;

  typedef enum int {STALL_NONE, STALL_SPARSE, STALL_RUNS} stall_mode_t;

  typedef struct {
    logic [PIX_W-1:0] pix;
    logic             last;
  } blur_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_func = FN_PIXEL;
  logic [PIX_W-1:0]     in_pixel_in = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PIX_W-1:0]     out_pixel_out;
  logic                 out_frame_last;

  // predictor state
  logic [PIX_W-1:0] ahead_row [MAX_W];
  logic [PIX_W-1:0] blur_row [MAX_W];
  logic [PIX_W-1:0] last_blur = '0;
  int unsigned      frame_pos = 0;
  logic [CFG_W-1:0] cfg_width = WIDTH_RESET;
  logic [CFG_W-1:0] cfg_height = HEIGHT_RESET;
  blur_result_t     pending_pixels [$];

  int unsigned burst_left = 0;
  bit          gaps_on = 1'b1;
  int unsigned n_items = 0;
  int unsigned n_results = 0;
  int unsigned n_frames = 0;
  int unsigned n_size_writes = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int unsigned stall_timer = 0;
  int unsigned run_left = 0;

  inplace_fade_blur_stream #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_pixel_in   (in_pixel_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel_out (out_pixel_out),
    .out_frame_last(out_frame_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned eff_width();
    if (cfg_width < 2) return 2;
    if (cfg_width > MAX_W) return MAX_W;
    return 32'(cfg_width);
  endfunction

  function automatic int unsigned eff_height();
    if (cfg_height < 1) return 1;
    if (cfg_height > MAX_H) return MAX_H;
    return 32'(cfg_height);
  endfunction

  // one item of the in-place blur; pushes the pixel it releases, if any
  function automatic void blur_step(input logic f, input logic [PIX_W-1:0] p);
    int unsigned      w, n, j, k;
    logic [PIX_W-1:0] cur, up, left, right;
    logic [PIX_W+1:0] sum;
    blur_result_t     r;
    w = eff_width();
    n = w * eff_height();
    j = frame_pos;
    cur = (j < n && f == FN_PIXEL) ? p : '0;
    if (j < w) begin
      ahead_row[j % w] = cur;
      frame_pos = j + 1;
      return;
    end
    k = j - w;
    up = (k >= w) ? blur_row[k % w] : '0;
    left = (k > 0) ? last_blur : '0;
    right = ahead_row[(j + 1) % w];
    sum = {2'b00, up & CHAN_MASK} + {2'b00, left & CHAN_MASK}
        + {2'b00, right & CHAN_MASK} + {2'b00, cur & CHAN_MASK};
    r.pix = sum[PIX_W+1:2];
    blur_row[k % w] = r.pix;
    last_blur = r.pix;
    ahead_row[j % w] = cur;
    r.last = (j >= n + w - 1);
    if (r.last) begin
      frame_pos = 0;
      last_blur = '0;
    end else begin
      frame_pos = j + 1;
    end
    pending_pixels.push_back(r);
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0: return '1;
      1: return '0;
      default: return PIX_W'($urandom_range(0, 32'hFFFFFF));
    endcase
  endfunction

  task automatic push_item(input logic f, input logic [PIX_W-1:0] p);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (gaps_on) gap = $urandom_range(1, 10);
    end
    burst_left--;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_pixel_in <= p;
    do @(posedge clk); while (in_stall);
    n_items++;
    blur_step(f, p);
  endtask

  task automatic send_random_item();
    logic f;
    if (frame_pos < eff_width() * eff_height())
      f = ($urandom_range(0, 9) == 0) ? FN_FLUSH : FN_PIXEL;
    else
      f = ($urandom_range(0, 4) == 0) ? FN_PIXEL : FN_FLUSH;
    push_item(f, rand_pixel());
  endtask

  task automatic send_frame();
    do send_random_item(); while (frame_pos != 0);
  endtask

  // stop sending, wait for every expected pixel, then let the pipe settle
  task automatic drain_pipeline(input int unsigned settle);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_frame_size(input int unsigned w, input int unsigned h);
    drain_pipeline(SETTLE_CYCLES);
    cfg_we <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data <= w[CFG_W-1:0];
    @(posedge clk);
    cfg_width = w[CFG_W-1:0];
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data <= h[CFG_W-1:0];
    @(posedge clk);
    cfg_height = h[CFG_W-1:0];
    cfg_we <= 1'b0;
    n_size_writes++;
  endtask

  task automatic pick_size(output int unsigned w, output int unsigned h);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      w = $urandom_range(0, 6);
      h = $urandom_range(0, 4);
    end else if (sel < 9) begin
      w = $urandom_range(7, 24);
      h = $urandom_range(1, 6);
    end else begin
      w = $urandom_range(25, 70);
      h = $urandom_range(1, 3);
    end
  endtask

  // a few items under the reset size, then a shrink that ends the frame at once
  task automatic test_reset_midframe();
    push_item(FN_PIXEL, 24'hFFFFFF);
    push_item(FN_PIXEL, 24'h000000);
    push_item(FN_PIXEL, 24'hA5A5A5);
    set_frame_size(2, 1);
    push_item(FN_PIXEL, 24'h123456);
  endtask

  // zero width and height saturate to 2 x 1
  task automatic test_min_size();
    set_frame_size(0, 0);
    push_item(FN_PIXEL, 24'hFFFFFF);
    push_item(FN_PIXEL, 24'hFFFFFF);
    push_item(FN_FLUSH, 24'h000000);
    push_item(FN_PIXEL, 24'hFFFFFF);
  endtask

  task automatic test_small_frame();
    set_frame_size(3, 2);
    push_item(FN_PIXEL, 24'hFFFFFF);
    push_item(FN_PIXEL, 24'h000000);
    push_item(FN_PIXEL, 24'hFCFCFC);
    push_item(FN_PIXEL, 24'h030303);
    push_item(FN_FLUSH, 24'hFFFFFF);
    push_item(FN_PIXEL, 24'hFFFFFF);
    push_item(FN_FLUSH, 24'h000000);
    push_item(FN_PIXEL, 24'hFFFFFF);
    push_item(FN_FLUSH, 24'h123456);
    // second frame back to back
    send_frame();
  endtask

  // oversized width runs as 1024 and oversized height as 1024; a shrink ends each
  task automatic test_size_limits();
    gaps_on = 1'b0;
    set_frame_size(2047, 1);
    repeat (MAX_W + 8) send_random_item();
    set_frame_size(2, 1);
    send_frame();
    set_frame_size(2, 2047);
    repeat (40) send_random_item();
    set_frame_size(3, 1);
    send_frame();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_frames();
    int unsigned w, h, cut, sent;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 6) begin
        pick_size(w, h);
        set_frame_size(w, h);
      end
      cut = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 40) : 0;
      do begin
        send_random_item();
        sent++;
        if (cut != 0) begin
          cut--;
          // resize in mid-frame
          if (cut == 0 && frame_pos != 0) begin
            pick_size(w, h);
            set_frame_size(w, h);
          end
        end
      end while (frame_pos != 0);
    end
  endtask

  initial begin
    foreach (ahead_row[i]) begin
      ahead_row[i] = '0;
      blur_row[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_midframe();
    test_min_size();
    test_small_frame();
    test_size_limits();
    test_random_frames();
    drain_pipeline(20);
    $display("Sent %0d items over %0d frame size settings, widths 2..1024, heights 1..1024.",
             n_items, n_size_writes);
    $display("Checked %0d blurred pixels closing %0d frames, %0d mismatches.",
             n_results, n_frames, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  always @(posedge clk) begin : check_results
    blur_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (out_frame_last) n_frames++;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected pixel %06h last %0b", $realtime, out_pixel_out,
                   out_frame_last);
      end else begin
        want = pending_pixels.pop_front();
        if (out_pixel_out !== want.pix || out_frame_last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: pixel exp %06h got %06h, last exp %0b got %0b", $realtime,
                     want.pix, out_pixel_out, want.last, out_frame_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (stall_timer == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 2));
      stall_timer <= $urandom_range(50, 300);
    end else begin
      stall_timer <= stall_timer - 1;
    end
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
      default: begin
        if (run_left == 0) begin
          out_stall <= !out_stall;
          run_left <= $urandom_range(1, 12);
        end else begin
          run_left <= run_left - 1;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d cycles without an accepted item", idle_cycles);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/ifb_pkg.sv
hw/rtl/ifb_ctrl.sv
hw/rtl/ifb_datapath.sv
hw/rtl/inplace_fade_blur_stream.sv
test/tb_inplace_fade_blur_stream.sv
